// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the keyed-removal queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: sv/fwkr_pkg.sv
// Types and constants of the keyed-removal queue.
`timescale 1ns / 1ps
package fwkr_pkg;

  localparam int ID_BITS      = 16;
  localparam int PROGRAM_BITS = 8;
  localparam int MARKS_BITS   = 10;
  localparam int FUNC_BITS    = 3;
  localparam int STATUS_BITS  = 2;
  localparam int OUT_CNT_BITS = 5;

  localparam logic [FUNC_BITS-1:0] FUNC_ENQ      = 3'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_DEQ      = 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_DEQ_PROG = 3'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_PEEK     = 3'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_POS      = 3'd4;
  localparam logic [FUNC_BITS-1:0] FUNC_REMOVE   = 3'd5;
  localparam logic [FUNC_BITS-1:0] FUNC_CLEAR    = 3'd6;

  localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_MISS  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    MATCH_HEAD,
    MATCH_ID,
    MATCH_PROG
  } match_e;

  typedef struct packed {
    logic [ID_BITS-1:0]      id;
    logic [PROGRAM_BITS-1:0] prog;
    logic [MARKS_BITS-1:0]   marks;
  } entry_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0]    func;
    logic [ID_BITS-1:0]      applicant_id;
    logic [PROGRAM_BITS-1:0] program_code;
    logic [MARKS_BITS-1:0]   marks_in;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]  status;
    logic [ID_BITS-1:0]      out_id;
    logic [PROGRAM_BITS-1:0] out_program;
    logic [MARKS_BITS-1:0]   out_marks;
    logic [OUT_CNT_BITS-1:0] position;
    logic [OUT_CNT_BITS-1:0] occupancy;
  } out_beat_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                    search;
    match_e                  mode;
    logic [ID_BITS-1:0]      key_id;
    logic [PROGRAM_BITS-1:0] key_prog;
    logic                    load;
    logic                    take;
    logic                    clear;
    entry_t                  wr_entry;
  } cell_ctl_t;

endpackage

// File: sv/fwkr_cell.sv
// One queue slot: stored entry, valid flag, registered key compare and shift logic.
`timescale 1ns / 1ps
module fwkr_cell import fwkr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      prev_valid_i,
  input  logic      prev_found_i,
  input  entry_t    next_entry_i,
  input  logic      next_valid_i,
  output entry_t    entry_o,
  output logic      valid_o,
  output logic      found_o,
  output logic      sel_o
);

  logic   valid_q, valid_d;
  logic   match_q, match_d;
  logic   take_here, load_here;
  entry_t entry_q;

  always_comb begin
    unique case (ctl_i.mode)
      MATCH_HEAD: match_d = valid_q;
      MATCH_ID:   match_d = valid_q && (entry_q.id == ctl_i.key_id);
      MATCH_PROG: match_d = valid_q && (entry_q.prog == ctl_i.key_prog);
      default:    match_d = 1'b0;
    endcase
  end

  assign found_o   = prev_found_i | match_q;
  assign sel_o     = match_q & ~prev_found_i;
  assign take_here = ctl_i.take & found_o;
  assign load_here = ctl_i.load & ~valid_q & prev_valid_i;

  always_comb begin
    priority if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (take_here) begin
      valid_d = next_valid_i;
    end else if (load_here) begin
      valid_d = 1'b1;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctl_i.search) begin
        match_q <= match_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_here) begin
      entry_q <= next_entry_i;
    end else if (load_here) begin
      entry_q <= ctl_i.wr_entry;
    end
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;

endmodule

// File: sv/fifo_with_keyed_removal_top.sv
// Top level of the keyed-removal queue: controller, cell chain and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Ordered queue of QUEUE_DEPTH entries (id, program, marks) held in a chain of
// cells. Each input beat is one operation: enqueue, dequeue, dequeue by
// program, peek, position of id, remove id or clear; each gives exactly one
// output beat. An item passes a search cycle in which every cell registers its
// own key compare, then an execute cycle in which the first hit is resolved
// along the cell chain; on a dequeue or removal the entries behind it shift
// one cell towards the head, and the result is registered. A new beat is
// taken in the execute cycle of the previous one, so back-to-back beats
// overlap; a stalled output holds the execute cycle. No clearing pass after
// reset.
module fifo_with_keyed_removal_top import fwkr_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EXEC
  } state_e;

  state_e          state_q;
  in_beat_t        op_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic            out_valid_q;
  out_beat_t       out_q, out_d;

  cell_ctl_t       ctl;
  logic            out_free, in_accept, exec_fire;
  logic            full, found;
  entry_t          hit_entry;
  logic [CNT_W-1:0] hit_pos;

  logic   [QUEUE_DEPTH-1:0] valid_w, found_w, sel_w;
  entry_t [QUEUE_DEPTH-1:0] entry_w;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~((state_q == ST_IDLE) || ((state_q == ST_EXEC) && out_free));
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign exec_fire  = (state_q == ST_EXEC) && out_free;

  always_comb begin
    ctl          = '0;
    ctl.search   = (state_q == ST_SEARCH);
    ctl.key_id   = op_q.applicant_id;
    ctl.key_prog = op_q.program_code;
    ctl.wr_entry = '{id: op_q.applicant_id, prog: op_q.program_code,
                     marks: op_q.marks_in};
    unique case (op_q.func)
      FUNC_DEQ_PROG:        ctl.mode = MATCH_PROG;
      FUNC_POS, FUNC_REMOVE: ctl.mode = MATCH_ID;
      default:              ctl.mode = MATCH_HEAD;
    endcase
    ctl.load  = exec_fire && (op_q.func == FUNC_ENQ);
    ctl.take  = exec_fire && ((op_q.func == FUNC_DEQ) || (op_q.func == FUNC_DEQ_PROG) ||
                              (op_q.func == FUNC_REMOVE));
    ctl.clear = exec_fire && (op_q.func == FUNC_CLEAR);
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   prev_valid, prev_found, next_valid;
    entry_t next_entry;
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_found = 1'b0;
    end else begin : g_body
      assign prev_valid = valid_w[i-1];
      assign prev_found = found_w[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_inner
      assign next_valid = valid_w[i+1];
      assign next_entry = entry_w[i+1];
    end
    fwkr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .prev_valid_i (prev_valid),
      .prev_found_i (prev_found),
      .next_entry_i (next_entry),
      .next_valid_i (next_valid),
      .entry_o      (entry_w[i]),
      .valid_o      (valid_w[i]),
      .found_o      (found_w[i]),
      .sel_o        (sel_w[i])
    );
  end

  assign full  = valid_w[QUEUE_DEPTH-1];
  assign found = found_w[QUEUE_DEPTH-1];

  always_comb begin
    hit_entry = '0;
    hit_pos   = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (sel_w[i]) begin
        hit_entry = hit_entry | entry_w[i];
        hit_pos   = hit_pos | CNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    out_d  = '0;
    fill_d = fill_q;
    unique case (op_q.func)
      FUNC_ENQ: begin
        if (full) begin
          out_d.status = STAT_FULL;
        end else begin
          fill_d = fill_q + CNT_W'(1);
        end
      end
      FUNC_DEQ, FUNC_DEQ_PROG, FUNC_REMOVE: begin
        if (found) begin
          out_d.out_id      = hit_entry.id;
          out_d.out_program = hit_entry.prog;
          out_d.out_marks   = hit_entry.marks;
          fill_d            = fill_q - CNT_W'(1);
        end else begin
          out_d.status = STAT_MISS;
        end
      end
      FUNC_PEEK: begin
        if (found) begin
          out_d.out_id      = hit_entry.id;
          out_d.out_program = hit_entry.prog;
          out_d.out_marks   = hit_entry.marks;
        end else begin
          out_d.status = STAT_MISS;
        end
      end
      FUNC_POS: begin
        if (found) begin
          out_d.position = OUT_CNT_BITS'(hit_pos);
        end else begin
          out_d.status = STAT_MISS;
        end
      end
      FUNC_CLEAR: fill_d = '0;
      default:    out_d.status = STAT_OK;
    endcase
    out_d.occupancy = OUT_CNT_BITS'(fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec_fire) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE:   if (in_accept) state_q <= ST_SEARCH;
        ST_SEARCH: state_q <= ST_EXEC;
        ST_EXEC: begin
          if (exec_fire) begin
            state_q <= in_accept ? ST_SEARCH : ST_IDLE;
          end
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q <= in_data_i;
    end
    if (exec_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= CNT_W'(QUEUE_DEPTH))
  `ASSERT_IMP(a_fill_cells, clk_i, rst_ni, 1'b1, $countones(valid_w) == int'(fill_q))
  `ASSERT_IMP(a_single_hit, clk_i, rst_ni, state_q == ST_EXEC, $onehot0(sel_w))
  `ASSERT_NXT(a_exec_result, clk_i, rst_ni, exec_fire, out_valid_q && (state_q != ST_EXEC))

endmodule
